### hdl/saoe_pkg.sv
// saoe_pkg: constants, codes and shared types of the slot allocator
// no dependencies
`timescale 1ns / 1ps

package saoe_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W    = 6;
    localparam int FRAME_W   = 32;
    localparam int COORD_W   = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam logic [FRAME_W-1:0] FRAME_AGE = FRAME_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INVAL   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FREE    = 3'd0,
        ST_EVICT   = 3'd1,
        ST_FAIL    = 3'd2,
        ST_REL     = 3'd3,
        ST_REL_IGN = 3'd4,
        ST_INVAL   = 3'd5,
        ST_NONE    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_NEXT,
        RD_LAST
    } rd_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_LAST,
        IDX_BEST,
        IDX_CNT
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [2:0] {
        ES_TOP,
        ES_RES,
        ES_SIDX,
        ES_PEND,
        ES_ZERO
    } emit_slot_t;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [FRAME_W-1:0]        frame_index;
        logic [SLOT_W-1:0]         slot_index;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]         slot;
        logic [FRAME_W-1:0]        frame;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } entry_t;

    typedef struct packed {
        logic       load;
        rd_sel_t    rd_sel;
        idx_op_t    idx_op;
        cnt_op_t    cnt_op;
        logic       wr_copy;
        logic       wr_new;
        logic       new_from_top;
        logic       pop;
        logic       push_sidx;
        logic       push_rd;
        logic       scan_clr;
        logic       scan_upd;
        logic       pend_set;
        logic       pend_clr;
        logic       emit;
        status_t    emit_status;
        emit_slot_t emit_slot;
        logic       emit_last;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic fcnt_nz;
        logic idx_eq_cnt;
        logic next_lt_cnt;
        logic slot_match;
        logic touch;
        logic idx_zero;
        logic cnt_zero;
        logic found;
        logic pend;
        logic out_busy;
    } dp_stat_t;

endpackage

### hdl/saoe_ifs.sv
// saoe_req_if and saoe_rsp_if: valid/ready channels of the slot allocator
// depends on saoe_pkg
`timescale 1ns / 1ps

interface saoe_req_if import saoe_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [FRAME_W-1:0]        frame_index;
    logic [SLOT_W-1:0]         slot_index;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;

    modport source (
        output valid, operation, frame_index, slot_index,
        output box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, operation, frame_index, slot_index,
        input  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface saoe_rsp_if import saoe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                last_result;

    modport source (output valid, status, slot, last_result, input ready);
    modport sink (input valid, status, slot, last_result, output ready);
endinterface

### hdl/saoe_datapath.sv
// saoe_datapath: entry list, free stack, cursor, eviction scan and result register
// depends on saoe_pkg
`timescale 1ns / 1ps

module saoe_datapath
    import saoe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  req_t                req,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [SLOT_W-1:0]   rsp_slot,
    output logic                rsp_last
);

    req_t                in_reg;
    entry_t              list_mem [NUM_SLOTS];
    logic [SLOT_W-1:0]   stack_mem [NUM_SLOTS];
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    fcnt_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic [CNT_W-1:0]    best_idx_reg;
    logic [FRAME_W-1:0]  best_frame_reg;
    logic                found_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                pend_reg;
    logic [SLOT_W-1:0]   pend_slot_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_last_reg;

    logic [CNT_W-1:0]    rd_ptr;
    logic [CNT_W-1:0]    cur_ptr;
    logic [CNT_W-1:0]    fcnt_m1;
    logic [CNT_W:0]      idx_p1;
    entry_t              rd;
    entry_t              cur;
    entry_t              new_entry;
    logic [SLOT_W-1:0]   top_slot;
    logic [SLOT_W-1:0]   emit_slot_val;
    logic [SLOT_W-1:0]   push_slot;
    logic [FRAME_W-1:0]  thr;
    logic                older;
    logic                better;

    assign idx_p1  = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign fcnt_m1 = fcnt_reg - CNT_W'(1);
    assign cur_ptr = idx_reg;
    assign cur     = list_mem[cur_ptr[IDX_W-1:0]];

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_CUR:  rd_ptr = idx_reg;
            RD_NEXT: rd_ptr = idx_p1[CNT_W-1:0];
            RD_LAST: rd_ptr = cnt_reg - CNT_W'(1);
            default: rd_ptr = idx_reg;
        endcase
    end

    assign rd       = list_mem[rd_ptr[IDX_W-1:0]];
    assign top_slot = stack_mem[fcnt_m1[IDX_W-1:0]];
    assign thr      = in_reg.frame_index - FRAME_AGE;
    assign older    = cur.frame < thr;
    assign better   = !found_reg || (cur.frame < best_frame_reg);

    always_comb
    begin
        new_entry.slot  = cmd.new_from_top ? top_slot : res_slot_reg;
        new_entry.frame = in_reg.frame_index;
        new_entry.min_x = in_reg.box_min_x;
        new_entry.min_y = in_reg.box_min_y;
        new_entry.min_z = in_reg.box_min_z;
        new_entry.max_x = in_reg.box_max_x;
        new_entry.max_y = in_reg.box_max_y;
        new_entry.max_z = in_reg.box_max_z;
    end

    assign push_slot = cmd.push_sidx ? in_reg.slot_index : cur.slot;

    always_comb
    begin
        unique case (cmd.emit_slot)
            ES_TOP:  emit_slot_val = top_slot;
            ES_RES:  emit_slot_val = res_slot_reg;
            ES_SIDX: emit_slot_val = in_reg.slot_index;
            ES_PEND: emit_slot_val = pend_slot_reg;
            ES_ZERO: emit_slot_val = '0;
            default: emit_slot_val = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_p1[CNT_W-1:0];
            IDX_DEC:  idx_next = idx_reg - CNT_W'(1);
            IDX_LAST: idx_next = cnt_reg - CNT_W'(1);
            IDX_BEST: idx_next = best_idx_reg;
            IDX_CNT:  idx_next = cnt_reg;
            default:  idx_next = idx_reg;
        endcase
    end

    // status toward the controller
    always_comb
    begin
        stat.op          = op_t'(in_reg.operation);
        stat.fcnt_nz     = fcnt_reg != '0;
        stat.idx_eq_cnt  = idx_reg == cnt_reg;
        stat.next_lt_cnt = idx_p1 < {1'b0, cnt_reg};
        stat.slot_match  = cur.slot == in_reg.slot_index;
        stat.touch       = (cur.min_x <= in_reg.box_max_x) && (cur.max_x >= in_reg.box_min_x)
                        && (cur.min_y <= in_reg.box_max_y) && (cur.max_y >= in_reg.box_min_y)
                        && (cur.min_z <= in_reg.box_max_z) && (cur.max_z >= in_reg.box_min_z);
        stat.idx_zero    = idx_reg == '0;
        stat.cnt_zero    = cnt_reg == '0;
        stat.found       = found_reg;
        stat.pend        = pend_reg;
        stat.out_busy    = out_valid_reg && !rsp_ready;
    end

    // entry list, request payload, eviction-scan best, pending slot and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= req;
        end
        if (cmd.wr_copy)
        begin
            list_mem[idx_reg[IDX_W-1:0]] <= rd;
        end
        else if (cmd.wr_new)
        begin
            list_mem[idx_reg[IDX_W-1:0]] <= new_entry;
        end
        if (cmd.scan_upd && older && better)
        begin
            best_idx_reg   <= idx_reg;
            best_frame_reg <= cur.frame;
            res_slot_reg   <= cur.slot;
        end
        if (cmd.pend_set)
        begin
            pend_slot_reg <= cur.slot;
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_slot_reg   <= emit_slot_val;
            out_last_reg   <= cmd.emit_last;
        end
    end

    // free stack, counters and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                stack_mem[k] <= SLOT_W'(k);
            end
            fcnt_reg      <= CNT_W'(NUM_SLOTS);
            cnt_reg       <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.pop)
            begin
                fcnt_reg <= fcnt_m1;
            end
            else if (cmd.push_sidx || cmd.push_rd)
            begin
                stack_mem[fcnt_reg[IDX_W-1:0]] <= push_slot;
                fcnt_reg                       <= fcnt_reg + CNT_W'(1);
            end
            unique case (cmd.cnt_op)
                CNT_HOLD: cnt_reg <= cnt_reg;
                CNT_INC:  cnt_reg <= cnt_reg + CNT_W'(1);
                CNT_DEC:  cnt_reg <= cnt_reg - CNT_W'(1);
                default:  cnt_reg <= cnt_reg;
            endcase
            if (cmd.scan_clr)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan_upd && older && better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.pend_clr)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.pend_set)
            begin
                pend_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_slot   = out_slot_reg;
    assign rsp_last   = out_last_reg;

endmodule

### hdl/saoe_ctrl.sv
// saoe_ctrl: sequencer for allocate, release and invalidate walks
// depends on saoe_pkg
`timescale 1ns / 1ps

module saoe_ctrl
    import saoe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC_FREE,
        S_EV_SCAN,
        S_EV_SHIFT,
        S_REL_SCAN,
        S_REL_SHIFT,
        S_INV_TEST,
        S_INV_COPY,
        S_INV_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.scan_clr = 1'b1;
                cmd.pend_clr = 1'b1;
                unique case (stat.op)
                    OP_ALLOC:
                    begin
                        if (stat.fcnt_nz)
                        begin
                            cmd.idx_op = IDX_CNT;
                            state_next = S_ALLOC_FREE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_EV_SCAN;
                        end
                    end
                    OP_RELEASE:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_REL_SCAN;
                    end
                    OP_INVAL:
                    begin
                        if (stat.cnt_zero)
                        begin
                            state_next = S_INV_END;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_LAST;
                            state_next = S_INV_TEST;
                        end
                    end
                    OP_NOP:  state_next = S_IDLE;
                    default: state_next = S_IDLE;
                endcase
            end
            S_ALLOC_FREE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.wr_new       = 1'b1;
                    cmd.new_from_top = 1'b1;
                    cmd.pop          = 1'b1;
                    cmd.cnt_op       = CNT_INC;
                    cmd.emit         = 1'b1;
                    cmd.emit_status  = ST_FREE;
                    cmd.emit_slot    = ES_TOP;
                    cmd.emit_last    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_EV_SCAN:
            begin
                if (stat.idx_eq_cnt)
                begin
                    if (stat.found)
                    begin
                        cmd.idx_op = IDX_BEST;
                        state_next = S_EV_SHIFT;
                    end
                    else if (!stat.out_busy)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_FAIL;
                        cmd.emit_slot   = ES_ZERO;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_upd = 1'b1;
                    cmd.idx_op   = IDX_INC;
                end
            end
            S_EV_SHIFT:
            begin
                if (stat.next_lt_cnt)
                begin
                    cmd.rd_sel  = RD_NEXT;
                    cmd.wr_copy = 1'b1;
                    cmd.idx_op  = IDX_INC;
                end
                else if (!stat.out_busy)
                begin
                    // evicted slot reused in the freed tail entry
                    cmd.wr_new      = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_EVICT;
                    cmd.emit_slot   = ES_RES;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_REL_SCAN:
            begin
                if (stat.idx_eq_cnt)
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_REL_IGN;
                        cmd.emit_slot   = ES_SIDX;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.slot_match)
                begin
                    state_next = S_REL_SHIFT;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_REL_SHIFT:
            begin
                if (stat.next_lt_cnt)
                begin
                    cmd.rd_sel  = RD_NEXT;
                    cmd.wr_copy = 1'b1;
                    cmd.idx_op  = IDX_INC;
                end
                else if (!stat.out_busy)
                begin
                    cmd.cnt_op      = CNT_DEC;
                    cmd.push_sidx   = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_REL;
                    cmd.emit_slot   = ES_SIDX;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_INV_TEST:
            begin
                if (stat.touch)
                begin
                    // previous hit goes out once the next one is known
                    if (!(stat.pend && stat.out_busy))
                    begin
                        cmd.emit        = stat.pend;
                        cmd.emit_status = ST_INVAL;
                        cmd.emit_slot   = ES_PEND;
                        cmd.pend_set    = 1'b1;
                        cmd.push_rd     = 1'b1;
                        state_next      = S_INV_COPY;
                    end
                end
                else if (stat.idx_zero)
                begin
                    state_next = S_INV_END;
                end
                else
                begin
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_INV_COPY:
            begin
                cmd.rd_sel  = RD_LAST;
                cmd.wr_copy = 1'b1;
                cmd.cnt_op  = CNT_DEC;
                if (stat.idx_zero)
                begin
                    state_next = S_INV_END;
                end
                else
                begin
                    cmd.idx_op = IDX_DEC;
                    state_next = S_INV_TEST;
                end
            end
            S_INV_END:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = stat.pend ? ST_INVAL : ST_NONE;
                    cmd.emit_slot   = stat.pend ? ES_PEND : ES_ZERO;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### hdl/slot_allocator_oldest_eviction_unit.sv
// slot_allocator_oldest_eviction_unit: slot pool with free stack and oldest-entry eviction
// depends on saoe_pkg, saoe_ifs, saoe_ctrl, saoe_datapath
//
// channel  dir  payload
// req      in   operation, frame_index, slot_index, box_min_x..box_max_z
// rsp      out  status, slot, last_result
//
// one request at a time; allocate takes a slot from the free stack, while
// eviction, release and invalidate walk the live list entries one by one
// reset restores the full free stack and an empty list at once
// a result waits in the output register; a stalled rsp holds the sequencer
`timescale 1ns / 1ps

module slot_allocator_oldest_eviction_unit
    import saoe_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    saoe_req_if.sink   req,
    saoe_rsp_if.source rsp
);

    req_t     req_data;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_comb
    begin
        req_data.operation   = req.operation;
        req_data.frame_index = req.frame_index;
        req_data.slot_index  = req.slot_index;
        req_data.box_min_x   = req.box_min_x;
        req_data.box_min_y   = req.box_min_y;
        req_data.box_min_z   = req.box_min_z;
        req_data.box_max_x   = req.box_max_x;
        req_data.box_max_y   = req.box_max_y;
        req_data.box_max_z   = req.box_max_z;
    end

    saoe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    saoe_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_data),
        .cmd        (cmd),
        .stat       (stat),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .rsp_status (rsp.status),
        .rsp_slot   (rsp.slot),
        .rsp_last   (rsp.last_result)
    );

endmodule
